[rtl/ssf_pkg.sv]
// shared types and constants for the serial flash device model
package ssf_pkg;

    // byte address width of the command protocol
    localparam int ADDR_W = 20;

    // fixed flash geometry
    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 65536;

    // request codes on req_type
    localparam logic [1:0] REQ_SELECT   = 2'd0;
    localparam logic [1:0] REQ_DESELECT = 2'd1;
    localparam logic [1:0] REQ_XFER     = 2'd2;

    // configuration register indexes
    localparam logic CFG_SIZE_SELECT = 1'b0;
    localparam logic CFG_DEVICE_ID   = 1'b1;

    // configuration reset values
    localparam logic [1:0]  SIZE_SELECT_RST = 2'd0;
    localparam logic [23:0] DEVICE_ID_RST   = 24'd2113555;

    // size select codes
    localparam logic [1:0] SIZE_256K = 2'd0;
    localparam logic [1:0] SIZE_512K = 2'd1;

    // opcodes
    localparam logic [7:0] OP_WREN = 8'h06;
    localparam logic [7:0] OP_WRDI = 8'h04;
    localparam logic [7:0] OP_RDID = 8'h9F;
    localparam logic [7:0] OP_RDSR = 8'h05;
    localparam logic [7:0] OP_READ = 8'h03;
    localparam logic [7:0] OP_FAST = 8'h0B;
    localparam logic [7:0] OP_PW   = 8'h0A;
    localparam logic [7:0] OP_PP   = 8'h02;
    localparam logic [7:0] OP_PE   = 8'hDB;
    localparam logic [7:0] OP_SE   = 8'hD8;
    localparam logic [7:0] OP_DP   = 8'hB9;
    localparam logic [7:0] OP_RDP  = 8'hAB;

    // byte driven when nothing else is, and the erased value
    localparam logic [7:0] IDLE_BYTE = 8'hFF;

    // status byte with the write enable latch set
    localparam logic [7:0] STATUS_WEL = 8'h02;

    // one access to the flash array per cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

[rtl/ssf_mem.sv]
// flash array: one write port, one registered read port
module ssf_mem #(
    parameter int MEM_BYTES = 262144
) (
    input  logic              clk,
    input  ssf_pkg::mem_req_t mem_req,
    output logic [7:0]        rd_data
);
    import ssf_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0] store [MEM_BYTES];

    // write and read, with the read data registered
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            store[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
        end
        rd_data <= store[mem_req.raddr[AW-1:0]];
    end

endmodule

[rtl/ssf_ctrl.sv]
// command protocol, sweep sequencer and configuration registers
module ssf_ctrl #(
    parameter int MEM_BYTES = 262144
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [1:0]                req_type,
    input  logic [7:0]                data_in,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [23:0]               cfg_data,
    input  logic [7:0]                rd_data,
    output ssf_pkg::mem_req_t         mem_req,
    output logic                      busy,
    output logic                      done,
    output logic [7:0]                data_out
);
    import ssf_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [ADDR_W-1:0] STORE_MASK = ADDR_W'(MEM_BYTES - 1);
    localparam logic [ADDR_W-1:0] PAGE_MASK  = ADDR_W'(PAGE_BYTES - 1);
    localparam logic [ADDR_W-1:0] SECT_MASK  = ADDR_W'(SECTOR_BYTES - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_PROG, S_ERASE
    } seq_t;

    typedef enum logic [3:0] {
        PH_DESELECTED, PH_COMMAND, PH_READ_ID, PH_READ_STATUS, PH_ADDR0,
        PH_ADDR1, PH_ADDR2, PH_DUMMY, PH_READ_DATA, PH_PAGE_WRITE,
        PH_PAGE_PROGRAM, PH_PAGE_ERASE, PH_SECTOR_ERASE, PH_IDLE
    } phase_t;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_WREN, CMD_WRDI, CMD_RDID, CMD_RDSR, CMD_READ, CMD_FAST,
        CMD_PW, CMD_PP, CMD_PE, CMD_SE, CMD_DP, CMD_RDP, CMD_OTHER
    } cmd_t;

    seq_t              seq_reg, seq_next;
    phase_t            phase_reg, phase_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              latch_reg, latch_next;
    logic              pd_reg, pd_next;
    logic [1:0]        size_reg, size_next;
    logic [23:0]       id_reg, id_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [AW-1:0]     last_reg, last_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] prog_addr_reg, prog_addr_next;
    logic [7:0]        prog_data_reg, prog_data_next;
    logic              done_reg, done_next;
    logic [7:0]        data_out_reg, data_out_next;

    logic [ADDR_W-1:0] addr_mask;
    logic [ADDR_W-1:0] addr_inc;
    logic [ADDR_W-1:0] addr_page_next;
    logic [ADDR_W-1:0] erase_base;
    cmd_t              op_cmd;

    // opcode decode
    function automatic cmd_t decode_op(input logic [7:0] op);
        cmd_t c;
        case (op)
            OP_WREN: c = CMD_WREN;
            OP_WRDI: c = CMD_WRDI;
            OP_RDID: c = CMD_RDID;
            OP_RDSR: c = CMD_RDSR;
            OP_READ: c = CMD_READ;
            OP_FAST: c = CMD_FAST;
            OP_PW:   c = CMD_PW;
            OP_PP:   c = CMD_PP;
            OP_PE:   c = CMD_PE;
            OP_SE:   c = CMD_SE;
            OP_DP:   c = CMD_DP;
            OP_RDP:  c = CMD_RDP;
            default: c = CMD_OTHER;
        endcase
        return c;
    endfunction

    // address mask from size select, limited to the store
    always_comb
    begin
        case (size_reg)
            SIZE_256K: addr_mask = 20'h3FFFF & STORE_MASK;
            SIZE_512K: addr_mask = 20'h7FFFF & STORE_MASK;
            default:   addr_mask = 20'hFFFFF & STORE_MASK;
        endcase
    end

    assign addr_inc       = addr_reg + ADDR_W'(1);
    assign addr_page_next = (addr_reg & ~PAGE_MASK) | (addr_inc & PAGE_MASK);
    assign erase_base     = (phase_reg == PH_PAGE_ERASE) ? (addr_reg & ~PAGE_MASK)
                                                          : (addr_reg & ~SECT_MASK);
    assign op_cmd         = decode_op(data_in);

    // next state of protocol and sequencer
    always_comb
    begin
        seq_next       = seq_reg;
        phase_next     = phase_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        latch_next     = latch_reg;
        pd_next        = pd_reg;
        size_next      = size_reg;
        id_next        = id_reg;
        sweep_next     = sweep_reg;
        last_next      = last_reg;
        base_next      = base_reg;
        prog_addr_next = prog_addr_reg;
        prog_data_next = prog_data_reg;
        done_next      = 1'b0;
        data_out_next  = data_out_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = '0;
        mem_req.wdata = IDLE_BYTE;
        mem_req.raddr = addr_reg & addr_mask;

        // configuration writes
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SIZE_SELECT: size_next = cfg_data[1:0];
                CFG_DEVICE_ID:   id_next = cfg_data;
                default:         id_next = id_reg;
            endcase
        end

        case (seq_reg)
            // blank the array after reset
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ADDR_W'(sweep_reg);
                mem_req.wdata = IDLE_BYTE;
                if (&sweep_reg)
                begin
                    seq_next = S_IDLE;
                end
                sweep_next = sweep_reg + AW'(1);
            end

            // take one item
            S_IDLE:
            begin
                if (start)
                begin
                    done_next     = 1'b1;
                    data_out_next = IDLE_BYTE;
                    case (req_type)
                        REQ_SELECT:
                        begin
                            if (phase_reg == PH_DESELECTED)
                            begin
                                phase_next = PH_COMMAND;
                            end
                        end
                        REQ_DESELECT:
                        begin
                            if (cmd_reg == CMD_PW || cmd_reg == CMD_PP ||
                                cmd_reg == CMD_PE || cmd_reg == CMD_SE)
                            begin
                                latch_next = 1'b0;
                            end
                            phase_next = PH_DESELECTED;
                        end
                        REQ_XFER:
                        begin
                            case (phase_reg)
                                PH_COMMAND:
                                begin
                                    if (pd_reg)
                                    begin
                                        if (op_cmd == CMD_RDP)
                                        begin
                                            pd_next    = 1'b0;
                                            phase_next = PH_IDLE;
                                        end
                                    end
                                    else
                                    begin
                                        cmd_next = op_cmd;
                                        case (op_cmd)
                                            CMD_WREN:
                                            begin
                                                latch_next = 1'b1;
                                                phase_next = PH_IDLE;
                                            end
                                            CMD_WRDI:
                                            begin
                                                latch_next = 1'b0;
                                                phase_next = PH_IDLE;
                                            end
                                            CMD_RDID:
                                            begin
                                                addr_next  = '0;
                                                phase_next = PH_READ_ID;
                                            end
                                            CMD_RDSR: phase_next = PH_READ_STATUS;
                                            CMD_READ, CMD_FAST: phase_next = PH_ADDR0;
                                            CMD_PW, CMD_PP, CMD_PE, CMD_SE:
                                            begin
                                                phase_next = latch_reg ? PH_ADDR0
                                                                       : PH_IDLE;
                                            end
                                            CMD_DP: pd_next = 1'b1;
                                            default: pd_next = pd_reg;
                                        endcase
                                    end
                                end
                                PH_READ_ID:
                                begin
                                    case (addr_reg[1:0])
                                        2'd0:    data_out_next = id_reg[23:16];
                                        2'd1:    data_out_next = id_reg[15:8];
                                        2'd2:    data_out_next = id_reg[7:0];
                                        default: data_out_next = IDLE_BYTE;
                                    endcase
                                    addr_next = addr_inc;
                                    if (addr_inc >= ADDR_W'(3))
                                    begin
                                        phase_next = PH_IDLE;
                                    end
                                end
                                PH_READ_STATUS:
                                begin
                                    data_out_next = latch_reg ? STATUS_WEL : 8'h00;
                                end
                                PH_ADDR0:
                                begin
                                    addr_next  = {data_in[3:0], 16'h0000};
                                    phase_next = PH_ADDR1;
                                end
                                PH_ADDR1:
                                begin
                                    addr_next  = addr_reg | {4'h0, data_in, 8'h00};
                                    phase_next = PH_ADDR2;
                                end
                                PH_ADDR2:
                                begin
                                    addr_next = (addr_reg | {12'h000, data_in}) & addr_mask;
                                    case (cmd_reg)
                                        CMD_READ: phase_next = PH_READ_DATA;
                                        CMD_FAST: phase_next = PH_DUMMY;
                                        CMD_PW:   phase_next = PH_PAGE_WRITE;
                                        CMD_PP:   phase_next = PH_PAGE_PROGRAM;
                                        CMD_PE:   phase_next = PH_PAGE_ERASE;
                                        CMD_SE:   phase_next = PH_SECTOR_ERASE;
                                        default:  phase_next = PH_IDLE;
                                    endcase
                                end
                                PH_DUMMY: phase_next = PH_READ_DATA;
                                PH_READ_DATA:
                                begin
                                    // array read issued now, result next cycle
                                    done_next = 1'b0;
                                    seq_next  = S_READ;
                                    addr_next = addr_inc;
                                end
                                PH_PAGE_WRITE:
                                begin
                                    mem_req.we    = 1'b1;
                                    mem_req.waddr = addr_reg & addr_mask;
                                    mem_req.wdata = data_in;
                                    addr_next     = addr_page_next;
                                end
                                PH_PAGE_PROGRAM:
                                begin
                                    // read now, and the masked byte goes back next cycle
                                    done_next      = 1'b0;
                                    seq_next       = S_PROG;
                                    prog_addr_next = addr_reg & addr_mask;
                                    prog_data_next = data_in;
                                    addr_next      = addr_page_next;
                                end
                                PH_PAGE_ERASE, PH_SECTOR_ERASE:
                                begin
                                    done_next  = 1'b0;
                                    seq_next   = S_ERASE;
                                    addr_next  = erase_base;
                                    base_next  = erase_base;
                                    sweep_next = '0;
                                    last_next  = (phase_reg == PH_PAGE_ERASE)
                                                 ? AW'(PAGE_BYTES - 1)
                                                 : AW'(SECTOR_BYTES - 1);
                                    phase_next = PH_IDLE;
                                end
                                default: phase_next = phase_reg;
                            endcase
                        end
                        default: phase_next = phase_reg;
                    endcase
                end
            end

            // array read data back
            S_READ:
            begin
                done_next     = 1'b1;
                data_out_next = rd_data;
                seq_next      = S_IDLE;
            end

            // program write-back
            S_PROG:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = prog_addr_reg;
                mem_req.wdata = rd_data & prog_data_reg;
                done_next     = 1'b1;
                data_out_next = IDLE_BYTE;
                seq_next      = S_IDLE;
            end

            // erase sweep, one byte a cycle
            S_ERASE:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = (base_reg | ADDR_W'(sweep_reg)) & addr_mask;
                mem_req.wdata = IDLE_BYTE;
                sweep_next    = sweep_reg + AW'(1);
                if (sweep_reg == last_reg)
                begin
                    done_next     = 1'b1;
                    data_out_next = IDLE_BYTE;
                    seq_next      = S_IDLE;
                end
            end

            default: seq_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= S_CLEAR;
            phase_reg     <= PH_DESELECTED;
            cmd_reg       <= CMD_NONE;
            addr_reg      <= '0;
            latch_reg     <= 1'b0;
            pd_reg        <= 1'b0;
            size_reg      <= SIZE_SELECT_RST;
            id_reg        <= DEVICE_ID_RST;
            sweep_reg     <= '0;
            last_reg      <= '0;
            base_reg      <= '0;
            prog_addr_reg <= '0;
            prog_data_reg <= '0;
            done_reg      <= 1'b0;
            data_out_reg  <= IDLE_BYTE;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            cmd_reg       <= cmd_next;
            addr_reg      <= addr_next;
            latch_reg     <= latch_next;
            pd_reg        <= pd_next;
            size_reg      <= size_next;
            id_reg        <= id_next;
            sweep_reg     <= sweep_next;
            last_reg      <= last_next;
            base_reg      <= base_next;
            prog_addr_reg <= prog_addr_next;
            prog_data_reg <= prog_data_next;
            done_reg      <= done_next;
            data_out_reg  <= data_out_next;
        end
    end

    assign busy     = (seq_reg != S_IDLE);
    assign done     = done_reg;
    assign data_out = data_out_reg;

endmodule

[rtl/spi_serial_flash_device_top.sv]
// top level of the byte-level serial flash device model
//
// An item (req_type, data_in) is taken at a clock edge with start high and
// busy low: select, deselect or one transferred byte. Each item gives one
// result byte on data_out, marked by done for exactly one cycle; the
// receiver takes it then and cannot stall it.
// Select, deselect, opcode, address and status/id bytes: done is registered
// and follows in the next cycle; a new item can be taken every cycle.
// Array reads and page program bytes: the array read is registered, so busy
// is high while the data returns and a program byte is written back.
// Page erase sweeps one page and sector erase one sector; the erase sweep
// writes one byte of the array per cycle and busy stays high meanwhile.
// Reset clears the protocol state and then blanks the whole array to 0xFF,
// one byte a cycle, with busy high. Configuration: cfg_wr_en with cfg_index
// 0 (size select) or 1 (device id) and cfg_data, written at the clock edge,
// only while idle: a rule for the user, which the block does not enforce.
module spi_serial_flash_device_top #(
    parameter int MEM_BYTES = 262144
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  data_in,
    output logic        done,
    output logic [7:0]  data_out,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);
    import ssf_pkg::*;

    mem_req_t   mem_req;
    logic [7:0] rd_data;

    // protocol and sequencer
    ssf_ctrl #(
        .MEM_BYTES(MEM_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .data_in  (data_in),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .rd_data  (rd_data),
        .mem_req  (mem_req),
        .busy     (busy),
        .done     (done),
        .data_out (data_out)
    );

    // flash array
    ssf_mem #(
        .MEM_BYTES(MEM_BYTES)
    ) u_mem (
        .clk    (clk),
        .mem_req(mem_req),
        .rd_data(rd_data)
    );

    // a result never shows while the block is still working
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // an accepted item gives a result or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted item neither finished nor in progress");

    // a result follows an accepted item or a busy cycle
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result without a cause");

endmodule

[sim/tb_spi_serial_flash_device_top.sv]
// testbench for the serial flash device: directed bus events, then random command traffic
`timescale 1ns / 1ps

module tb_spi_serial_flash_device_top;
    import ssf_pkg::*;

    localparam int MEM_BYTES    = 262144;
    localparam int N_DIRECTED   = 42;
    localparam int RANDOM_ITEMS = 800;
    localparam int N_PHASES     = 6;
    localparam int TAIL_CYCLES  = 32;
    localparam int STALL_LIMIT  = 1000000;

    // request code outside the defined set
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // size select codes beyond the package ones
    localparam logic [1:0] SIZE_1M   = 2'd2;
    localparam logic [1:0] SIZE_OVER = 2'd3;

    // status byte with the write enable latch clear
    localparam logic [7:0] STATUS_CLEAR = 8'h00;

    // opcodes the random commands pick from
    localparam logic [7:0] OPCODE_SET [12] = '{OP_WREN, OP_WRDI, OP_RDID, OP_RDSR, OP_READ,
        OP_FAST, OP_PW, OP_PP, OP_PE, OP_SE, OP_DP, OP_RDP};

    typedef enum logic [3:0] {
        PH_DESEL, PH_OPCODE, PH_ID, PH_STATUS, PH_ADDR_HI, PH_ADDR_MID, PH_ADDR_LO,
        PH_DUMMY, PH_READOUT, PH_PAGE_WRITE, PH_PROGRAM, PH_PAGE_ERASE, PH_SECTOR_ERASE,
        PH_IDLE
    } bus_phase_t;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_WREN, CMD_WRDI, CMD_RDID, CMD_RDSR, CMD_READ, CMD_FAST, CMD_PW,
        CMD_PP, CMD_PE, CMD_SE, CMD_DP, CMD_RDP, CMD_OTHER
    } flash_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] din;
        logic       typed;
        logic [7:0] want;
    } bus_row_t;

    // directed bus events; rows with typed set carry their own data_out
    localparam bus_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // stray events and chained opcodes in one selection
        '{REQ_XFER,     8'h00,   1'b1, IDLE_BYTE},
        '{REQ_UNKNOWN,  8'hFF,   1'b1, IDLE_BYTE},
        '{REQ_SELECT,   8'h00,   1'b1, IDLE_BYTE},
        '{REQ_SELECT,   8'hFF,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     8'h00,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     OP_RDP,  1'b1, IDLE_BYTE},
        '{REQ_XFER,     OP_DP,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     OP_WREN, 1'b1, IDLE_BYTE},
        '{REQ_XFER,     OP_RDP,  1'b1, IDLE_BYTE},
        '{REQ_DESELECT, 8'h00,   1'b1, IDLE_BYTE},
        // status with latch clear
        '{REQ_SELECT,   8'h00,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     OP_RDSR, 1'b1, IDLE_BYTE},
        '{REQ_XFER,     8'hFF,   1'b1, STATUS_CLEAR},
        '{REQ_DESELECT, 8'hFF,   1'b1, IDLE_BYTE},
        // id bytes, then idle
        '{REQ_SELECT,   8'h00,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     OP_RDID, 1'b1, IDLE_BYTE},
        '{REQ_XFER,     8'h00,   1'b1, DEVICE_ID_RST[23:16]},
        '{REQ_XFER,     8'hFF,   1'b1, DEVICE_ID_RST[15:8]},
        '{REQ_XFER,     8'h00,   1'b1, DEVICE_ID_RST[7:0]},
        '{REQ_XFER,     8'hFF,   1'b1, IDLE_BYTE},
        '{REQ_DESELECT, 8'h00,   1'b1, IDLE_BYTE},
        // write enable, then page write at the top of the array wrapping in the page
        '{REQ_SELECT,   8'h00,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     OP_WREN, 1'b1, IDLE_BYTE},
        '{REQ_DESELECT, 8'h00,   1'b1, IDLE_BYTE},
        '{REQ_SELECT,   8'h00,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     OP_PW,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     8'hFF,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     8'hFF,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     8'hFE,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     8'h5A,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     8'hA5,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     8'hC3,   1'b1, IDLE_BYTE},
        '{REQ_DESELECT, 8'h00,   1'b1, IDLE_BYTE},
        // fast read across the end of the array
        '{REQ_SELECT,   8'h00,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     OP_FAST, 1'b1, IDLE_BYTE},
        '{REQ_XFER,     8'h0F,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     8'hFF,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     8'hFE,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     8'h00,   1'b1, IDLE_BYTE},
        '{REQ_XFER,     8'h00,   1'b0, IDLE_BYTE},
        '{REQ_XFER,     8'hFF,   1'b0, IDLE_BYTE},
        '{REQ_XFER,     8'h00,   1'b0, IDLE_BYTE}
    };

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [7:0]  data_in;
    logic        done;
    logic [7:0]  data_out;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [23:0] cfg_data;

    // typed data_out that goes with the item on the bus
    logic        row_typed;
    logic [7:0]  row_want;

    // shadow of the device
    logic [1:0]  size_sel = SIZE_SELECT_RST;
    logic [23:0] dev_id = DEVICE_ID_RST;
    bus_phase_t  ph = PH_DESEL;
    flash_cmd_t  cmd = CMD_NONE;
    logic [19:0] addr = '0;
    logic        wel = 1'b0;
    logic        deep_sleep = 1'b0;
    logic [7:0]  flash_mem [MEM_BYTES];

    logic [7:0]  data_out_due [$];
    int          fail_count = 0;
    int          stall_cycles = 0;
    int          items_sent = 0;
    int          gap_odds = 0;
    int          erase_budget = 4;

    spi_serial_flash_device_top #(
        .MEM_BYTES(MEM_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .data_in(data_in),
        .done(done),
        .data_out(data_out),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic flash_cmd_t decode_op(input logic [7:0] op);
        case (op)
            OP_WREN: return CMD_WREN;
            OP_WRDI: return CMD_WRDI;
            OP_RDID: return CMD_RDID;
            OP_RDSR: return CMD_RDSR;
            OP_READ: return CMD_READ;
            OP_FAST: return CMD_FAST;
            OP_PW:   return CMD_PW;
            OP_PP:   return CMD_PP;
            OP_PE:   return CMD_PE;
            OP_SE:   return CMD_SE;
            OP_DP:   return CMD_DP;
            OP_RDP:  return CMD_RDP;
            default: return CMD_OTHER;
        endcase
    endfunction

    function automatic logic [19:0] size_mask();
        logic [19:0] m;
        if (size_sel == SIZE_256K)
            m = 20'h3FFFF;
        else if (size_sel == SIZE_512K)
            m = 20'h7FFFF;
        else
            m = 20'hFFFFF;
        return m & 20'(MEM_BYTES - 1);
    endfunction

    // erased bytes wrap within the address mask
    function automatic void blank_span(input logic [19:0] base, input int len);
        int m;
        m = int'(size_mask());
        for (int i = 0; i < len; i++)
            flash_mem[(int'(base) + i) & m] = IDLE_BYTE;
    endfunction

    // advance within the current page
    function automatic logic [19:0] page_next(input logic [19:0] a);
        return (a & ~20'(PAGE_BYTES - 1)) | ((a + 20'd1) & 20'(PAGE_BYTES - 1));
    endfunction

    // one bus event on the shadow device, returns the byte shifted out
    function automatic logic [7:0] flash_bus_event(input logic [1:0] req, input logic [7:0] d);
        logic [19:0] m;
        logic [7:0]  r;
        flash_cmd_t  c;
        m = size_mask();
        r = IDLE_BYTE;
        case (req)
            REQ_SELECT:
                if (ph == PH_DESEL)
                    ph = PH_OPCODE;
            REQ_DESELECT:
            begin
                if (cmd == CMD_PW || cmd == CMD_PP || cmd == CMD_PE || cmd == CMD_SE)
                    wel = 1'b0;
                ph = PH_DESEL;
            end
            REQ_XFER:
                case (ph)
                    PH_OPCODE:
                    begin
                        c = decode_op(d);
                        if (deep_sleep)
                        begin
                            // only release is obeyed while asleep
                            if (c == CMD_RDP)
                            begin
                                deep_sleep = 1'b0;
                                ph = PH_IDLE;
                            end
                        end
                        else
                        begin
                            cmd = c;
                            case (c)
                                CMD_WREN:
                                begin
                                    wel = 1'b1;
                                    ph = PH_IDLE;
                                end
                                CMD_WRDI:
                                begin
                                    wel = 1'b0;
                                    ph = PH_IDLE;
                                end
                                CMD_RDID:
                                begin
                                    addr = '0;
                                    ph = PH_ID;
                                end
                                CMD_RDSR: ph = PH_STATUS;
                                CMD_READ, CMD_FAST: ph = PH_ADDR_HI;
                                CMD_PW, CMD_PP, CMD_PE, CMD_SE:
                                    ph = wel ? PH_ADDR_HI : PH_IDLE;
                                CMD_DP: deep_sleep = 1'b1;
                                default: ;
                            endcase
                        end
                    end
                    PH_ID:
                    begin
                        case (addr[1:0])
                            2'd0: r = dev_id[23:16];
                            2'd1: r = dev_id[15:8];
                            2'd2: r = dev_id[7:0];
                            default: r = IDLE_BYTE;
                        endcase
                        addr = addr + 20'd1;
                        if (addr >= 20'd3)
                            ph = PH_IDLE;
                    end
                    PH_STATUS: r = wel ? STATUS_WEL : STATUS_CLEAR;
                    PH_ADDR_HI:
                    begin
                        addr = {d[3:0], 16'h0000};
                        ph = PH_ADDR_MID;
                    end
                    PH_ADDR_MID:
                    begin
                        addr = addr | {4'h0, d, 8'h00};
                        ph = PH_ADDR_LO;
                    end
                    PH_ADDR_LO:
                    begin
                        addr = (addr | {12'h000, d}) & m;
                        case (cmd)
                            CMD_READ: ph = PH_READOUT;
                            CMD_FAST: ph = PH_DUMMY;
                            CMD_PW:   ph = PH_PAGE_WRITE;
                            CMD_PP:   ph = PH_PROGRAM;
                            CMD_PE:   ph = PH_PAGE_ERASE;
                            CMD_SE:   ph = PH_SECTOR_ERASE;
                            default:  ph = PH_IDLE;
                        endcase
                    end
                    PH_DUMMY: ph = PH_READOUT;
                    PH_READOUT:
                    begin
                        r = flash_mem[addr & m];
                        addr = addr + 20'd1;
                    end
                    PH_PAGE_WRITE:
                    begin
                        flash_mem[addr & m] = d;
                        addr = page_next(addr);
                    end
                    PH_PROGRAM:
                    begin
                        flash_mem[addr & m] = flash_mem[addr & m] & d;
                        addr = page_next(addr);
                    end
                    PH_PAGE_ERASE:
                    begin
                        addr = addr & ~20'(PAGE_BYTES - 1);
                        blank_span(addr, PAGE_BYTES);
                        ph = PH_IDLE;
                    end
                    PH_SECTOR_ERASE:
                    begin
                        addr = addr & ~20'(SECTOR_BYTES - 1);
                        blank_span(addr, SECTOR_BYTES);
                        ph = PH_IDLE;
                    end
                    default: ;
                endcase
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_failure(input logic [7:0] want, input logic [7:0] got, input bit spurious);
        fail_count++;
        if (fail_count <= 10)
        begin
            if (spurious)
                $display("%0t: data_out 0x%02h with no item outstanding", $time, got);
            else
                $display("%0t: data_out expected 0x%02h got 0x%02h", $time, want, got);
        end
    endtask

    // results, register writes and accepted items, all seen at the rising edge
    always @(posedge clk)
    begin : monitor
        logic [7:0] due;
        logic [7:0] predicted;
        if (rst_n)
        begin
            if (done)
            begin
                if (data_out_due.size() == 0)
                    note_failure(IDLE_BYTE, data_out, 1'b1);
                else
                begin
                    due = data_out_due.pop_front();
                    if (data_out !== due)
                        note_failure(due, data_out, 1'b0);
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_SIZE_SELECT)
                    size_sel = cfg_data[1:0];
                else
                    dev_id = cfg_data;
            end
            if (start && !busy)
            begin
                predicted = flash_bus_event(req_type, data_in);
                data_out_due.push_back(row_typed ? row_want : predicted);
            end
        end
        if (done || (start && !busy))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
    end

    // watchdog on cycles with no item accepted and no result
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // drive one item at the falling edge and hold it until taken
    task automatic send_item(input logic [1:0] req, input logic [7:0] d, input logic typed,
                             input logic [7:0] want);
        int gap;
        @(negedge clk);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            gap = $urandom_range(1, 13);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req_type <= req;
        data_in <= d;
        row_typed <= typed;
        row_want <= want;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic send(input logic [1:0] req, input logic [7:0] d);
        send_item(req, d, 1'b0, IDLE_BYTE);
    endtask

    // hold off until every result is in and the device is free
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (data_out_due.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [23:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // half the addresses cluster on a few pages so reads find written data
    function automatic logic [23:0] pick_addr();
        logic [7:0] hi_set [3];
        logic [7:0] mid_set [3];
        hi_set = '{8'h00, 8'h03, 8'hF3};
        mid_set = '{8'h00, 8'h01, 8'hFF};
        if ($urandom_range(0, 1) == 0)
            return 24'($urandom);
        return {hi_set[$urandom_range(0, 2)], mid_set[$urandom_range(0, 2)],
                8'($urandom)};
    endfunction

    // one random command: mostly well formed, some noise and broken ones
    task automatic run_command();
        int          pick;
        int          n;
        int          n_addr;
        logic [7:0]  op;
        logic [7:0]  lead_set [3];
        logic [23:0] a;
        lead_set = '{8'h00, 8'hFF, OP_RDP};
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send(2'($urandom_range(0, 3)), 8'($urandom));
        end
        else
        begin
            n = $urandom_range(0, 12);
            op = (n == 12) ? 8'($urandom) : OPCODE_SET[n];
            if (op == OP_SE)
            begin
                if (erase_budget == 0)
                    op = OP_PE;
                else
                    erase_budget--;
            end
            // write enable ahead of most write-type commands
            if ((op == OP_PW || op == OP_PP || op == OP_PE || op == OP_SE) &&
                $urandom_range(0, 3) != 0)
            begin
                send(REQ_SELECT, 8'($urandom));
                send(REQ_XFER, OP_WREN);
                send(REQ_DESELECT, 8'($urandom));
            end
            send(REQ_SELECT, 8'($urandom));
            if ($urandom_range(0, 9) == 0)
                send(REQ_XFER, lead_set[$urandom_range(0, 2)]);
            send(REQ_XFER, op);
            if (op == OP_READ || op == OP_FAST || op == OP_PW || op == OP_PP ||
                op == OP_PE || op == OP_SE)
            begin
                a = pick_addr();
                n_addr = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 2) : 3;
                for (int k = 0; k < n_addr; k++)
                    send(REQ_XFER, a[23 - 8 * k -: 8]);
                if (n_addr == 3)
                begin
                    if (op == OP_FAST)
                        send(REQ_XFER, 8'($urandom));
                    n = (op == OP_PE || op == OP_SE) ? $urandom_range(1, 2)
                                                     : $urandom_range(1, 8);
                    repeat (n) send(REQ_XFER, 8'($urandom));
                end
            end
            else
            begin
                n = $urandom_range(0, 4);
                repeat (n) send(REQ_XFER, 8'($urandom));
            end
            if ($urandom_range(0, 19) != 0)
                send(REQ_DESELECT, 8'($urandom));
        end
    endtask

    initial
    begin
        logic [23:0] size_word;
        logic [23:0] id_word;
        foreach (flash_mem[i])
            flash_mem[i] = IDLE_BYTE;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_SELECT;
        data_in = 8'h00;
        row_typed = 1'b0;
        row_want = IDLE_BYTE;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_SIZE_SELECT;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed events under reset settings
        for (int r = 0; r < N_DIRECTED; r++)
            send_item(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].din, DIRECTED_ROWS[r].typed,
                      DIRECTED_ROWS[r].want);

        // random phases, each with its own settings
        items_sent = 0;
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    size_word = {22'h000000, SIZE_256K};
                    id_word = 24'h000000;
                    gap_odds = 4;
                end
                1:
                begin
                    size_word = {22'h3FFFFF, SIZE_OVER};
                    id_word = 24'hFFFFFF;
                    gap_odds = 3;
                end
                2:
                begin
                    size_word = {22'($urandom), SIZE_512K};
                    id_word = 24'($urandom);
                    gap_odds = 0;
                end
                3:
                begin
                    size_word = {22'($urandom), SIZE_1M};
                    id_word = 24'($urandom);
                    gap_odds = 6;
                end
                4:
                begin
                    size_word = 24'($urandom);
                    id_word = 24'($urandom);
                    gap_odds = 2;
                end
                default:
                begin
                    size_word = 24'($urandom);
                    id_word = 24'($urandom);
                    gap_odds = 0;
                end
            endcase
            drain();
            write_reg(CFG_SIZE_SELECT, size_word);
            write_reg(CFG_DEVICE_ID, id_word);
            while (items_sent < (p + 1) * RANDOM_ITEMS / N_PHASES)
            begin
                run_command();
                if ($urandom_range(0, 29) == 0)
                    drain();
            end
        end

        // wind down
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (data_out_due.size() != 0)
        begin
            $display("%0d results never arrived", data_out_due.size());
            fail_count = fail_count + data_out_due.size();
        end
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
